// ----- rtl/rrs_pkg.sv -----
// Shared types and constants for the round-robin scheduler.
// No dependencies; imported by every rtl module.
`timescale 1ns / 1ps

package rrs_pkg;

  localparam int MAX_PROCS = 16;
  localparam int PID_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int ID_W      = 4;

  localparam logic [2:0] EV_RUN     = 3'd0;
  localparam logic [2:0] EV_DONE    = 3'd1;
  localparam logic [2:0] EV_EXPIRED = 3'd2;
  localparam logic [2:0] EV_IDLE    = 3'd3;
  localparam logic [2:0] EV_REJECT  = 3'd4;

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [ID_W-1:0] proc_id;
    logic [15:0]     service_time;
    logic [15:0]     deadline;
  } in_req_t;

  typedef struct packed {
    logic [2:0]      event_res;
    logic [ID_W-1:0] run_id;
    logic [31:0]     turnaround;
    logic [31:0]     wait_time;
    logic            deadline_met;
  } out_res_t;

  // process table word
  typedef struct packed {
    logic [31:0] stamp;
    logic [15:0] service;
    logic [15:0] remaining;
    logic [15:0] deadline;
  } pent_t;

  typedef struct packed {
    logic             we;
    logic [PID_W-1:0] waddr;
    pent_t            wdata;
    logic             re;
    logic [PID_W-1:0] raddr;
  } ptab_ctl_t;

  typedef struct packed {
    logic             push;
    logic [PID_W-1:0] push_id;
    logic             pop;
  } qctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [PID_W-1:0] rd_id;
  } qstat_t;

endpackage

// ----- rtl/round_robin_scheduler.sv -----
// Round-robin time-slice scheduler, top level.
// Depends on rrs_pkg, rrs_ptab, rrs_rdyq.
`timescale 1ns / 1ps
//
//  channel | ports                        | moves
//  --------+------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data  | arrival or tick request
//  out     | out_valid, out_ready, out_data | one result per tick/reject
//  cfg     | cfg_we, cfg_wdata            | quantum register write
//
// An accepted arrival stays in IDLE; a rejected one goes to OUT. A tick
// passes TRD and OUT when the CPU keeps its process, QRD, TRD and OUT
// when it dispatches (queue RAM read, then table RAM read), and OUT alone
// when idle. An accepted arrival writes its table entry directly; a tick
// that runs a process ends in a read-modify-write of its entry.
// Synchronous active-low reset clears control state; RAM contents are
// left as they are. A stalled out channel holds the result register and
// the next result waits in the OUT state; in_ready is low until then.

module round_robin_scheduler (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rrs_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rrs_pkg::out_res_t out_data,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);
  import rrs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,   // take a request
    S_QRD  = 4'b0010,   // queue head read in flight
    S_TRD  = 4'b0100,   // table entry read in flight
    S_OUT  = 4'b1000    // hand result to output register
  } state_t;

  state_t           state_r, state_nxt;
  logic [7:0]       quantum_r;
  logic [31:0]      time_r, time_nxt;
  logic [MAX_PROCS-1:0] mask_r, mask_nxt;
  logic             run_valid_r, run_valid_nxt;
  logic [PID_W-1:0] running_id_r, running_id_nxt;
  logic [7:0]       slice_r, slice_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [PID_W-1:0] pend_id_r, pend_id_nxt;
  out_res_t         res_r, res_nxt;
  logic [15:0]      svc_r, svc_nxt;
  logic [15:0]      dl_r, dl_nxt;
  logic             out_valid_r;
  out_res_t         out_data_r;
  out_res_t         res_fin;

  ptab_ctl_t        tctl;
  pent_t            trd;
  qctl_t            qctl;
  qstat_t           qstat;

  logic             accept, reject;
  logic [PID_W-1:0] pid_idx;
  logic [7:0]       slice_dec;
  logic [31:0]      ta;
  logic             slot_free;

  rrs_ptab u_ptab (
    .clk   (clk),
    .ctl   (tctl),
    .rdata (trd)
  );

  rrs_rdyq u_rdyq (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (qctl),
    .stat  (qstat)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign pid_idx   = PID_W'(in_data.proc_id);
  // ids past the table, or already active, are turned away
  assign reject    = (32'(in_data.proc_id) >= MAX_PROCS) || mask_r[pid_idx];
  assign slice_dec = (slice_r != 8'd0) ? slice_r - 8'd1 : 8'd0;
  assign ta        = time_r - trd.stamp;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    time_nxt       = time_r;
    mask_nxt       = mask_r;
    run_valid_nxt  = run_valid_r;
    running_id_nxt = running_id_r;
    slice_nxt      = slice_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    res_nxt        = res_r;
    svc_nxt        = svc_r;
    dl_nxt         = dl_r;
    tctl           = '0;
    qctl           = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          if (in_data.req_type == REQ_ARRIVAL) begin
            if (reject) begin
              res_nxt.event_res = EV_REJECT;
              res_nxt.run_id    = in_data.proc_id;
              state_nxt         = S_OUT;
            end else begin
              // register and enqueue in the same cycle; no result
              mask_nxt[pid_idx]       = 1'b1;
              tctl.we                 = 1'b1;
              tctl.waddr              = pid_idx;
              tctl.wdata.stamp        = time_r;
              tctl.wdata.service      = in_data.service_time;
              tctl.wdata.remaining    = in_data.service_time;
              tctl.wdata.deadline     = in_data.deadline;
              qctl.push               = 1'b1;
              qctl.push_id            = pid_idx;
            end
          end else begin
            time_nxt       = time_r + 32'd1;
            // requeue last tick's preempted process ahead of dispatch
            qctl.push      = pend_valid_r;
            qctl.push_id   = pend_id_r;
            pend_valid_nxt = 1'b0;
            if (!run_valid_r && (pend_valid_r || (qstat.count != '0))) begin
              qctl.pop      = 1'b1;
              run_valid_nxt = 1'b1;
              slice_nxt     = (quantum_r == 8'd0) ? 8'd1 : quantum_r;
              state_nxt     = S_QRD;
            end else if (run_valid_r) begin
              tctl.re    = 1'b1;
              tctl.raddr = running_id_r;
              state_nxt  = S_TRD;
            end else begin
              res_nxt.event_res = EV_IDLE;
              state_nxt         = S_OUT;
            end
          end
        end
      end

      S_QRD: begin
        running_id_nxt = qstat.rd_id;
        tctl.re        = 1'b1;
        tctl.raddr     = qstat.rd_id;
        state_nxt      = S_TRD;
      end

      S_TRD: begin
        slice_nxt      = slice_dec;
        res_nxt.run_id = ID_W'(running_id_r);
        tctl.we        = 1'b1;
        tctl.waddr     = running_id_r;
        tctl.wdata     = trd;
        if (trd.remaining <= 16'd1) begin
          tctl.wdata.remaining   = 16'd0;
          mask_nxt[running_id_r] = 1'b0;
          run_valid_nxt          = 1'b0;
          res_nxt.event_res      = EV_DONE;
          res_nxt.turnaround     = ta;
          svc_nxt                = trd.service;
          dl_nxt                 = trd.deadline;
        end else begin
          tctl.wdata.remaining = trd.remaining - 16'd1;
          if (slice_dec == 8'd0) begin
            run_valid_nxt     = 1'b0;
            pend_valid_nxt    = 1'b1;
            pend_id_nxt       = running_id_r;
            res_nxt.event_res = EV_EXPIRED;
          end else begin
            res_nxt.event_res = EV_RUN;
          end
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // finish statistics filled in on the way to the output register
  always_comb begin
    res_fin = res_r;
    if (res_r.event_res == EV_DONE) begin
      res_fin.wait_time    = res_r.turnaround - {16'd0, svc_r};
      res_fin.deadline_met = (res_r.turnaround <= {16'd0, dl_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      quantum_r    <= 8'd2;
      time_r       <= '0;
      mask_r       <= '0;
      run_valid_r  <= 1'b0;
      slice_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      time_r       <= time_nxt;
      mask_r       <= mask_nxt;
      run_valid_r  <= run_valid_nxt;
      slice_r      <= slice_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (cfg_we) begin
        quantum_r <= cfg_wdata;
      end
      if (state_r == S_OUT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    running_id_r <= running_id_nxt;
    pend_id_r    <= pend_id_nxt;
    res_r        <= res_nxt;
    svc_r        <= svc_nxt;
    dl_r         <= dl_nxt;
    if (state_r == S_OUT && slot_free) begin
      out_data_r <= res_fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/rrs_ptab.sv -----
// Process table: one synchronous RAM word per process id.
// Depends on rrs_pkg.
`timescale 1ns / 1ps

module rrs_ptab (
  input  logic              clk,
  input  rrs_pkg::ptab_ctl_t ctl,
  output rrs_pkg::pent_t    rdata
);
  import rrs_pkg::*;

  pent_t mem [MAX_PROCS];
  pent_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[ctl.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rrs_rdyq.sv -----
// Ready queue: circular FIFO of process ids held in a synchronous RAM.
// Depends on rrs_pkg. Pop data appears in the cycle after pop.
`timescale 1ns / 1ps

module rrs_rdyq (
  input  logic           clk,
  input  logic           rst_n,
  input  rrs_pkg::qctl_t ctl,
  output rrs_pkg::qstat_t stat
);
  import rrs_pkg::*;

  logic [PID_W-1:0] mem [MAX_PROCS];
  logic [PID_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PID_W-1:0] rd_r;
  logic [PID_W:0]   tail_sum;
  logic [PID_W-1:0] tail;
  logic             full, push_ok, fwd;

  assign full     = (count_r == CNT_W'(MAX_PROCS));
  assign push_ok  = ctl.push && !full;
  assign tail_sum = {1'b0, head_r} + (PID_W+1)'(count_r);
  assign tail     = (tail_sum >= (PID_W+1)'(MAX_PROCS)) ?
                    PID_W'(tail_sum - (PID_W+1)'(MAX_PROCS)) : tail_sum[PID_W-1:0];
  // push into an empty queue and pop in the same cycle: same address
  assign fwd      = ctl.pop && push_ok && (count_r == '0);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r + CNT_W'(push_ok) - CNT_W'(ctl.pop);
    if (ctl.pop) begin
      head_nxt = (head_r == PID_W'(MAX_PROCS - 1)) ? '0 : head_r + PID_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= ctl.push_id;
    end
    if (ctl.pop) begin
      rd_r <= fwd ? ctl.push_id : mem[head_r];
    end
  end

  assign stat.count = count_r;
  assign stat.rd_id = rd_r;

endmodule

// ----- rtl/rrs_checker.sv -----
// Port-level checks for round_robin_scheduler, bound to the top level.
// Depends on rrs_pkg and round_robin_scheduler.
`timescale 1ns / 1ps

module rrs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input rrs_pkg::out_res_t out_data
);
  import rrs_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.event_res <= EV_REJECT))
    else $error("event code out of range");

  // timing fields only carry data on a finish
  a_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res != EV_DONE) |->
      (out_data.turnaround == 32'd0) && (out_data.wait_time == 32'd0) &&
      !out_data.deadline_met)
    else $error("timing fields set on a non-finish result");

  a_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == EV_IDLE) |-> (out_data.run_id == '0))
    else $error("idle result carries an id");

  // turnaround minus wait is the 16-bit service time
  a_wait_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == EV_DONE) |->
      ((out_data.turnaround - out_data.wait_time) <= 32'h0000_FFFF))
    else $error("wait time inconsistent with turnaround");

endmodule

bind round_robin_scheduler rrs_checker u_rrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- verif/tb.sv -----
// Self-checking testbench for the round-robin time-slice scheduler.
// Depends on rrs_pkg and round_robin_scheduler; predicts every result in-bench.
`timescale 1ns / 1ps

module tb;
  import rrs_pkg::*;

  // Cycles with no handshake on either channel before the run is called hung.
  // The slowest request is a dispatching tick; the rest is a sender gap or a
  // receiver stall, each geometric at 60 percent.
  localparam int STUCK_LIMIT = 4000;
  // Cycles to let an accepted arrival, which produces no result, drain out.
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS = 150;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // One row of the directed table: a request or a quantum write. The typed-in
  // result, where present, replaces the predicted one.
  typedef struct {
    row_kind_e kind;
    in_req_t   req;
    logic [7:0] quantum;
    bit        typed;
    out_res_t  exp;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_res_t out_data;
  logic     cfg_we;
  logic [7:0] cfg_wdata;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int stuck = 0;

  out_res_t exp_events[$];
  stim_row_t stim_table[$];

  // Scheduler state as the predictor sees it
  logic [31:0] sim_ticks = '0;
  logic [31:0] ent_stamp[MAX_PROCS];
  logic [15:0] ent_service[MAX_PROCS];
  logic [15:0] ent_remaining[MAX_PROCS];
  logic [15:0] ent_deadline[MAX_PROCS];
  logic [MAX_PROCS-1:0] proc_active = '0;
  logic [3:0]  rq_mem[MAX_PROCS];
  logic [3:0]  rq_head = '0;
  logic [4:0]  rq_count = '0;
  logic        cpu_busy = 1'b0;
  logic [3:0]  cpu_id = '0;
  logic [7:0]  slice_cnt = '0;
  logic        requeue_valid = 1'b0;
  logic [3:0]  requeue_id = '0;
  logic [7:0]  quantum_cfg = 8'd2;

  round_robin_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void ready_push(logic [3:0] id);
    if (rq_count < 5'(MAX_PROCS)) begin
      rq_mem[rq_head + rq_count[3:0]] = id;
      rq_count = rq_count + 5'd1;
    end
  endfunction

  // Applies one accepted request to the predicted state; returns 1 when the
  // request produces a result, which is then left in res.
  function automatic bit schedule_step(in_req_t r, output out_res_t res);
    logic [3:0]  id;
    logic [31:0] ta;
    res = '0;
    if (r.req_type == REQ_ARRIVAL) begin
      if (proc_active[r.proc_id]) begin
        // duplicate id: rejected, nothing changes
        res.event_res = EV_REJECT;
        res.run_id = r.proc_id;
        return 1'b1;
      end
      proc_active[r.proc_id] = 1'b1;
      ent_stamp[r.proc_id] = sim_ticks;
      ent_service[r.proc_id] = r.service_time;
      ent_remaining[r.proc_id] = r.service_time;
      ent_deadline[r.proc_id] = r.deadline;
      ready_push(r.proc_id);
      return 1'b0;
    end
    // last tick's preempted process goes behind arrivals made since then
    if (requeue_valid) begin
      ready_push(requeue_id);
      requeue_valid = 1'b0;
    end
    if (!cpu_busy && rq_count != 5'd0) begin
      cpu_id = rq_mem[rq_head];
      rq_head = rq_head + 4'd1;
      rq_count = rq_count - 5'd1;
      cpu_busy = 1'b1;
      slice_cnt = (quantum_cfg == 8'd0) ? 8'd1 : quantum_cfg;
    end
    sim_ticks = sim_ticks + 32'd1;
    if (!cpu_busy) begin
      res.event_res = EV_IDLE;
      return 1'b1;
    end
    id = cpu_id;
    res.run_id = id;
    if (slice_cnt != 8'd0) slice_cnt = slice_cnt - 8'd1;
    if (ent_remaining[id] <= 16'd1) begin
      // zero service time lands here too, after a single tick
      ta = sim_ticks - ent_stamp[id];
      ent_remaining[id] = '0;
      proc_active[id] = 1'b0;
      cpu_busy = 1'b0;
      res.event_res = EV_DONE;
      res.turnaround = ta;
      res.wait_time = ta - {16'd0, ent_service[id]};
      res.deadline_met = (ta <= {16'd0, ent_deadline[id]});
      return 1'b1;
    end
    ent_remaining[id] = ent_remaining[id] - 16'd1;
    if (slice_cnt == 8'd0) begin
      cpu_busy = 1'b0;
      requeue_valid = 1'b1;
      requeue_id = id;
      res.event_res = EV_EXPIRED;
      return 1'b1;
    end
    res.event_res = EV_RUN;
    return 1'b1;
  endfunction

  // Mostly ticks and arrivals of free ids with short service; now and then a
  // duplicate id, a zero or a full 16-bit service time, a wide deadline.
  function automatic in_req_t rand_req();
    in_req_t r;
    int free_n;
    int pick;
    r.req_type = ($urandom_range(0, 99) < 55) ? REQ_TICK : REQ_ARRIVAL;
    r.proc_id = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 39))
      0:       r.service_time = 16'($urandom_range(0, 65535));
      1:       r.service_time = 16'd0;
      default: r.service_time = 16'($urandom_range(1, 12));
    endcase
    r.deadline = $urandom_range(0, 1) ? 16'($urandom_range(0, 40))
                                      : 16'($urandom_range(0, 65535));
    if (r.req_type == REQ_ARRIVAL && $urandom_range(0, 99) < 85) begin
      free_n = 0;
      for (int i = 0; i < MAX_PROCS; i++) if (!proc_active[i]) free_n++;
      if (free_n > 0) begin
        pick = $urandom_range(0, free_n - 1);
        for (int i = 0; i < MAX_PROCS; i++) begin
          if (!proc_active[i]) begin
            if (pick == 0) r.proc_id = 4'(i);
            pick--;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic stim_row_t req_row(logic rt, int pid, int svc, int dl);
    stim_row_t row;
    row.kind = ROW_REQ;
    row.req.req_type = rt;
    row.req.proc_id = 4'(pid);
    row.req.service_time = 16'(svc);
    row.req.deadline = 16'(dl);
    row.quantum = '0;
    row.typed = 1'b0;
    row.exp = '0;
    return row;
  endfunction

  function automatic stim_row_t with_exp(stim_row_t row, logic [2:0] ev, int id,
                                         int ta, int wt, logic dm);
    row.typed = 1'b1;
    row.exp.event_res = ev;
    row.exp.run_id = 4'(id);
    row.exp.turnaround = 32'(ta);
    row.exp.wait_time = 32'(wt);
    row.exp.deadline_met = dm;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(int q);
    stim_row_t row;
    row = req_row(REQ_TICK, 0, 0, 0);
    row.kind = ROW_CFG;
    row.quantum = 8'(q);
    return row;
  endfunction

  // Presents one request, holds it until accepted, then records what it
  // should produce. in_valid is left high: the caller either presents the
  // next request or lowers it in the same time step.
  task automatic send_req(in_req_t r, bit typed, out_res_t typed_exp);
    out_res_t res;
    bit has_res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has_res = schedule_step(r, res);
    if (has_res) exp_events.push_back(typed ? typed_exp : res);
  endtask

  // Quantum writes happen only with the block idle: sender holds off until
  // every expected result has come, plus time for a trailing arrival.
  task automatic write_quantum(logic [7:0] q);
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= q;
    @(posedge clk);
    cfg_we <= 1'b0;
    quantum_cfg = q;
  endtask

  // Receiver: ready drawn fresh every cycle at the phase's stall rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    out_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (exp_events.size() == 0) begin
        $display("%0t: result with nothing expected: ev=%0d id=%0d ta=%h wt=%h dm=%b",
                 $time, out_data.event_res, out_data.run_id, out_data.turnaround,
                 out_data.wait_time, out_data.deadline_met);
        errors++;
      end else begin
        want = exp_events.pop_front();
        if (out_data.event_res !== want.event_res || out_data.run_id !== want.run_id ||
            out_data.turnaround !== want.turnaround ||
            out_data.wait_time !== want.wait_time ||
            out_data.deadline_met !== want.deadline_met) begin
          $display("%0t: mismatch expected ev=%0d id=%0d ta=%h wt=%h dm=%b",
                   $time, want.event_res, want.run_id, want.turnaround,
                   want.wait_time, want.deadline_met);
          $display("%0t:          actual   ev=%0d id=%0d ta=%h wt=%h dm=%b",
                   $time, out_data.event_res, out_data.run_id, out_data.turnaround,
                   out_data.wait_time, out_data.deadline_met);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long with no request or result moving means a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck = 0;
    else stuck++;
    if (stuck >= STUCK_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;

    // Directed table. Quantum starts at its reset value of 2.
    stim_table.push_back(with_exp(req_row(REQ_TICK, 0, 0, 0), EV_IDLE, 0, 0, 0, 0));
    stim_table.push_back(req_row(REQ_ARRIVAL, 15, 16'hFFFF, 16'hFFFF));
    stim_table.push_back(with_exp(req_row(REQ_ARRIVAL, 15, 1, 0), EV_REJECT, 15, 0, 0, 0));
    stim_table.push_back(req_row(REQ_ARRIVAL, 0, 0, 0));        // zero service time
    stim_table.push_back(with_exp(req_row(REQ_TICK, 0, 0, 0), EV_RUN, 15, 0, 0, 0));
    stim_table.push_back(with_exp(req_row(REQ_TICK, 0, 0, 0), EV_EXPIRED, 15, 0, 0, 0));
    stim_table.push_back(with_exp(req_row(REQ_TICK, 0, 0, 0), EV_DONE, 0, 3, 3, 0));
    stim_table.push_back(req_row(REQ_ARRIVAL, 1, 1, 16'hFFFF));
    stim_table.push_back(req_row(REQ_TICK, 0, 0, 0));
    stim_table.push_back(req_row(REQ_TICK, 0, 0, 0));
    stim_table.push_back(req_row(REQ_TICK, 0, 0, 0));
    stim_table.push_back(cfg_row(0));                           // zero quantum acts as one
    stim_table.push_back(req_row(REQ_ARRIVAL, 2, 3, 2));
    stim_table.push_back(req_row(REQ_TICK, 0, 0, 0));
    stim_table.push_back(req_row(REQ_TICK, 0, 0, 0));
    // arrival lands ahead of the process preempted on the tick before
    stim_table.push_back(req_row(REQ_ARRIVAL, 3, 2, 0));
    stim_table.push_back(req_row(REQ_TICK, 0, 0, 0));
    stim_table.push_back(req_row(REQ_TICK, 0, 0, 0));
    stim_table.push_back(with_exp(req_row(REQ_ARRIVAL, 3, 5, 5), EV_REJECT, 3, 0, 0, 0));
    stim_table.push_back(cfg_row(255));
    stim_table.push_back(req_row(REQ_TICK, 0, 0, 0));
    stim_table.push_back(req_row(REQ_TICK, 0, 0, 0));
    stim_table.push_back(req_row(REQ_TICK, 0, 0, 0));
    stim_table.push_back(req_row(REQ_TICK, 0, 0, 0));
    stim_table.push_back(cfg_row(2));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) write_quantum(stim_table[i].quantum);
      else send_req(stim_table[i].req, stim_table[i].typed, stim_table[i].exp);
    end

    // Random phases: no idling, sender idle, receiver stalling, both a little.
    // Each phase starts with a quantum write, so the sender drains first.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_quantum(8'd1); send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin write_quantum(8'd3); send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin write_quantum(8'd0); send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin
          write_quantum(8'($urandom_range(1, 6)));
          send_idle_pct = 11;
          recv_stall_pct = 11;
        end
      endcase
      repeat (PHASE_ITEMS) send_req(rand_req(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
